[sv/quadratic_root_solver_defines.svh]
// assertion macros for the quadratic root solver
// used by the top level only; expects clk and rst_n in scope
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// property that must hold at every edge outside reset
`define QRS_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("qrs check failed");

// property that must hold whenever the condition holds
`define QRS_ASSERT_IMPLIES(lbl, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("qrs check failed");

`endif

[sv/qrs_pkg.sv]
// shared types and constants for the quadratic root solver
// no dependencies; every design and testbench file uses it by scoped names
package qrs_pkg;

    localparam int COEF_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int TOL_WIDTH  = 16;
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(655);

    localparam int MAG_W   = COEF_WIDTH;
    localparam int PROD_W  = 2 * COEF_WIDTH;
    localparam int DISC_W  = 2 * COEF_WIDTH + 1;
    localparam int SQRT_W  = COEF_WIDTH + 1;
    localparam int SQ_IN_W = 2 * SQRT_W;
    localparam int REM_W   = SQRT_W + 2;
    localparam int NMAG_W  = SQRT_W + 1;
    localparam int NUM_W   = NMAG_W + FRAC_BITS + 1;
    localparam int DEN_W   = COEF_WIDTH + 1;

    typedef enum logic [1:0] {
        ST_NOT_QUAD = 2'd0,
        ST_NO_REAL  = 2'd1,
        ST_DOUBLE   = 2'd2,
        ST_TWO      = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] coef_a;
        logic signed [COEF_WIDTH-1:0] coef_b;
        logic signed [COEF_WIDTH-1:0] coef_c;
    } coef_t;

    typedef struct packed {
        status_t                      status;
        logic [1:0]                   root_count;
        logic signed [COEF_WIDTH-1:0] root_one;
        logic signed [COEF_WIDTH-1:0] root_two;
        logic                         saturated;
    } result_t;

    typedef struct packed {
        status_t          status;
        logic             a_neg;
        logic [MAG_W-1:0] a_mag;
        logic             b_neg;
        logic [MAG_W-1:0] b_mag;
    } root_side_t;

    typedef struct packed {
        root_side_t        side;
        logic [DISC_W-1:0] d_mag;
    } disc_t;

    typedef struct packed {
        root_side_t        side;
        logic [SQRT_W-1:0] root;
    } sq_out_t;

    typedef struct packed {
        status_t                    status;
        logic [1:0]                 neg;
        logic [DEN_W-1:0]           den;
        logic [1:0][NUM_W-1:0]      num;
    } div_word_t;

endpackage

[sv/qrs_front.sv]
// front end: sign split, squares and products, discriminant and classification
// three register stages; uses qrs_pkg
module qrs_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  qrs_pkg::coef_t               coef,
    input  logic [qrs_pkg::TOL_WIDTH-1:0] tol,
    output logic                         out_valid,
    output qrs_pkg::disc_t               dout
);

    localparam int MW = qrs_pkg::MAG_W;

    logic          a_neg, b_neg, c_neg;
    logic [MW-1:0] a_raw, b_raw, c_raw, a_mag, b_mag, c_mag;

    // sign and magnitude split
    always_comb
    begin
        a_raw = coef.coef_a;
        b_raw = coef.coef_b;
        c_raw = coef.coef_c;
        a_neg = a_raw[MW-1];
        b_neg = b_raw[MW-1];
        c_neg = c_raw[MW-1];
        a_mag = a_neg ? (~a_raw + MW'(1)) : a_raw;
        b_mag = b_neg ? (~b_raw + MW'(1)) : b_raw;
        c_mag = c_neg ? (~c_raw + MW'(1)) : c_raw;
    end

    // stage 1 registers
    logic                           v1_reg;
    logic                           quad1_reg, a_neg1_reg, b_neg1_reg, c_neg1_reg;
    logic [MW-1:0]                  a_mag1_reg, b_mag1_reg, c_mag1_reg;
    logic [qrs_pkg::TOL_WIDTH-1:0]  tol1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quad1_reg  <= (a_mag != '0) && (a_mag >= MW'(tol));
            a_neg1_reg <= a_neg;
            b_neg1_reg <= b_neg;
            c_neg1_reg <= c_neg;
            a_mag1_reg <= a_mag;
            b_mag1_reg <= b_mag;
            c_mag1_reg <= c_mag;
            tol1_reg   <= tol;
        end
    end

    // stage 2: b squared and a times c
    logic                              v2_reg, quad2_reg, acpos2_reg;
    logic                              a_neg2_reg, b_neg2_reg;
    logic [MW-1:0]                     a_mag2_reg, b_mag2_reg;
    logic [qrs_pkg::PROD_W-1:0]        b2_reg, ac_reg;
    logic [qrs_pkg::TOL_WIDTH-1:0]     tol2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b2_reg     <= qrs_pkg::PROD_W'(b_mag1_reg) * qrs_pkg::PROD_W'(b_mag1_reg);
            ac_reg     <= qrs_pkg::PROD_W'(a_mag1_reg) * qrs_pkg::PROD_W'(c_mag1_reg);
            acpos2_reg <= (a_neg1_reg == c_neg1_reg) || (c_mag1_reg == '0);
            quad2_reg  <= quad1_reg;
            a_neg2_reg <= a_neg1_reg;
            b_neg2_reg <= b_neg1_reg;
            a_mag2_reg <= a_mag1_reg;
            b_mag2_reg <= b_mag1_reg;
            tol2_reg   <= tol1_reg;
        end
    end

    // discriminant with a sign bit on top, then classify
    logic [qrs_pkg::DISC_W:0]   ac4, b2x, d_full;
    logic [qrs_pkg::DISC_W-1:0] tz;
    qrs_pkg::status_t           status_next;

    always_comb
    begin
        ac4    = {ac_reg, 2'b00};
        b2x    = (qrs_pkg::DISC_W + 1)'(b2_reg);
        d_full = acpos2_reg ? (b2x - ac4) : (b2x + ac4);
        tz     = qrs_pkg::DISC_W'({tol2_reg, {qrs_pkg::FRAC_BITS{1'b0}}});
        if (!quad2_reg)
        begin
            status_next = qrs_pkg::ST_NOT_QUAD;
        end
        else if (acpos2_reg && d_full[qrs_pkg::DISC_W])
        begin
            status_next = qrs_pkg::ST_NO_REAL;
        end
        else if ((d_full[qrs_pkg::DISC_W-1:0] == '0) || (d_full[qrs_pkg::DISC_W-1:0] < tz))
        begin
            status_next = qrs_pkg::ST_DOUBLE;
        end
        else
        begin
            status_next = qrs_pkg::ST_TWO;
        end
    end

    // stage 3 registers
    logic           v3_reg;
    qrs_pkg::disc_t d3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d3_reg.side.status <= status_next;
            d3_reg.side.a_neg  <= a_neg2_reg;
            d3_reg.side.a_mag  <= a_mag2_reg;
            d3_reg.side.b_neg  <= b_neg2_reg;
            d3_reg.side.b_mag  <= b_mag2_reg;
            d3_reg.d_mag       <= d_full[qrs_pkg::DISC_W-1:0];
        end
    end

    assign out_valid = v3_reg;
    assign dout      = d3_reg;

endmodule

[sv/qrs_sqrt.sv]
// pipelined integer square root, one result bit per register stage
// carries the item's side fields along; uses qrs_pkg
module qrs_sqrt (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  qrs_pkg::disc_t   din,
    output logic             out_valid,
    output qrs_pkg::sq_out_t dout
);

    localparam int N  = qrs_pkg::SQRT_W;
    localparam int RW = qrs_pkg::REM_W;
    localparam int IW = qrs_pkg::SQ_IN_W;

    logic                  v_st    [0:N];
    qrs_pkg::root_side_t   side_st [0:N];
    logic [RW-1:0]         rem_st  [0:N];
    logic [N-1:0]          root_st [0:N];
    logic [IW-1:0]         rad_st  [0:N];

    assign v_st[0]    = in_valid;
    assign side_st[0] = din.side;
    assign rem_st[0]  = '0;
    assign root_st[0] = '0;
    assign rad_st[0]  = IW'(din.d_mag);

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_step
            logic [RW-1:0]       rem_sh, trial, rem_next;
            logic [N-1:0]        root_next;
            logic                ge;
            logic                v_reg;
            qrs_pkg::root_side_t side_reg;
            logic [RW-1:0]       rem_reg;
            logic [N-1:0]        root_reg;
            logic [IW-1:0]       rad_reg;

            // bring down two radicand bits and try the next root bit
            always_comb
            begin
                rem_sh    = {rem_st[k][RW-3:0], rad_st[k][IW-1 -: 2]};
                trial     = {root_st[k], 2'b01};
                ge        = (rem_sh >= trial);
                rem_next  = ge ? (rem_sh - trial) : rem_sh;
                root_next = {root_st[k][N-2:0], ge};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg <= 1'b0;
                end
                else if (en)
                begin
                    v_reg <= v_st[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    side_reg <= side_st[k];
                    rem_reg  <= rem_next;
                    root_reg <= root_next;
                    rad_reg  <= {rad_st[k][IW-3:0], 2'b00};
                end
            end

            assign v_st[k+1]    = v_reg;
            assign side_st[k+1] = side_reg;
            assign rem_st[k+1]  = rem_reg;
            assign root_st[k+1] = root_reg;
            assign rad_st[k+1]  = rad_reg;
        end
    endgenerate

    assign out_valid = v_st[N];
    assign dout.side = side_st[N];
    assign dout.root = root_st[N];

endmodule

[sv/qrs_div.sv]
// pipelined restoring divider for both roots, one quotient bit per stage
// numerator bits shift out as quotient bits shift in; uses qrs_pkg
module qrs_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  qrs_pkg::div_word_t din,
    output logic               out_valid,
    output qrs_pkg::div_word_t dout
);

    localparam int NW = qrs_pkg::NUM_W;
    localparam int DW = qrs_pkg::DEN_W;

    logic                v_st   [0:NW];
    qrs_pkg::div_word_t  w_st   [0:NW];
    logic [1:0][DW-1:0]  rem_st [0:NW];

    assign v_st[0]   = in_valid;
    assign w_st[0]   = din;
    assign rem_st[0] = '0;

    genvar k, j;
    generate
        for (k = 0; k < NW; k++)
        begin : g_step
            qrs_pkg::div_word_t w_next;
            logic [1:0][DW-1:0] rem_next;
            logic               v_reg;
            qrs_pkg::div_word_t w_reg;
            logic [1:0][DW-1:0] rem_reg;

            for (j = 0; j < 2; j++)
            begin : g_lane
                logic [DW:0] rem_sh, den_x;
                logic        ge;

                // shift in a numerator bit and subtract where it fits
                always_comb
                begin
                    rem_sh = {rem_st[k][j], w_st[k].num[j][NW-1]};
                    den_x  = {1'b0, w_st[k].den};
                    ge     = (rem_sh >= den_x);
                end

                assign rem_next[j] = ge ? DW'(rem_sh - den_x) : rem_sh[DW-1:0];
                assign w_next.num[j] = {w_st[k].num[j][NW-2:0], ge};
            end

            assign w_next.status = w_st[k].status;
            assign w_next.neg    = w_st[k].neg;
            assign w_next.den    = w_st[k].den;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg <= 1'b0;
                end
                else if (en)
                begin
                    v_reg <= v_st[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    w_reg   <= w_next;
                    rem_reg <= rem_next;
                end
            end

            assign v_st[k+1]   = v_reg;
            assign w_st[k+1]   = w_reg;
            assign rem_st[k+1] = rem_reg;
        end
    endgenerate

    assign out_valid = v_st[NW];
    assign dout      = w_st[NW];

endmodule

[sv/quadratic_root_solver.sv]
// Real roots of a*x^2 + b*x + c = 0 for signed Q16.16 coefficients.
// Input channel: in_valid / in_stall with the coefficients in coef; one
// transfer is one equation. Output channel: out_valid / out_stall with
// status, root count, both roots and a saturation flag in result.
// The tolerance register is written through cfg_wr_en / cfg_wr_data and
// holds 655 (0.01) after reset; write it only while the block is empty.
// From input transfer to result valid an equation passes three front
// stages (split, multiply, discriminant), 33 square root stages, one stage
// forming the numerators, 51 divider stages and the output register.
// One equation is taken per cycle while no held result stalls the pipeline;
// the square root and divider pipelines each retire one result bit per stage.
// Reset empties every stage; nothing is in flight afterwards.
// While a result waits and out_stall is high, the whole pipeline holds
// and in_stall is raised; items in flight are kept, none is dropped.
// Depends on qrs_pkg, qrs_front, qrs_sqrt, qrs_div and the defines header.
`include "quadratic_root_solver_defines.svh"

module quadratic_root_solver (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [qrs_pkg::TOL_WIDTH-1:0] cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  qrs_pkg::coef_t                coef,
    output logic                          out_valid,
    input  logic                          out_stall,
    output qrs_pkg::result_t              result
);

    localparam int CW = qrs_pkg::COEF_WIDTH;
    localparam int NW = qrs_pkg::NUM_W;
    localparam int TW = qrs_pkg::SQRT_W + 2;

    logic                          en;
    logic [qrs_pkg::TOL_WIDTH-1:0] tol_reg;
    logic                          out_valid_reg;
    qrs_pkg::result_t              result_reg;

    // pipeline advances unless a finished result is held back
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= qrs_pkg::TOL_RESET;
        end
        else if (cfg_wr_en)
        begin
            tol_reg <= cfg_wr_data;
        end
    end

    logic             front_valid, sq_valid, div_valid;
    qrs_pkg::disc_t   front_out;
    qrs_pkg::sq_out_t sq_out;
    qrs_pkg::div_word_t div_out;

    qrs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .coef      (coef),
        .tol       (tol_reg),
        .out_valid (front_valid),
        .dout      (front_out)
    );

    qrs_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .din       (front_out),
        .out_valid (sq_valid),
        .dout      (sq_out)
    );

    // numerators +-sqrt(d) - b with rounding offset, divisor 2a
    logic [TW-1:0]              s_x, b_x, t_x;
    logic [1:0][TW-1:0]         n_x;
    logic [1:0][TW-1:0]         n_mag;
    qrs_pkg::div_word_t         num_next;

    always_comb
    begin
        s_x = (sq_out.side.status == qrs_pkg::ST_TWO) ? TW'(sq_out.root) : '0;
        b_x = TW'(sq_out.side.b_mag);
        t_x = sq_out.side.b_neg ? b_x : (~b_x + TW'(1));
        n_x[0] = t_x + s_x;
        n_x[1] = t_x - s_x;
        num_next.status = sq_out.side.status;
        num_next.den    = {sq_out.side.a_mag, 1'b0};
        for (int j = 0; j < 2; j++)
        begin
            n_mag[j] = n_x[j][TW-1] ? (~n_x[j] + TW'(1)) : n_x[j];
            num_next.neg[j] = (n_x[j][TW-1] != sq_out.side.a_neg) && (n_mag[j] != '0);
            num_next.num[j] = NW'({n_mag[j][qrs_pkg::NMAG_W-1:0],
                                   {qrs_pkg::FRAC_BITS{1'b0}}})
                              + NW'(sq_out.side.a_mag);
        end
    end

    logic               num_valid_reg;
    qrs_pkg::div_word_t num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            num_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_next;
        end
    end

    qrs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (num_valid_reg),
        .din       (num_reg),
        .out_valid (div_valid),
        .dout      (div_out)
    );

    // clamp, restore sign and assemble the result
    logic [1:0][NW-1:0] lim;
    logic [1:0]         sat;
    logic [1:0][CW-1:0] mag, root;
    logic               has_roots;
    qrs_pkg::result_t   result_next;

    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            lim[j]  = NW'({1'b0, {(CW-1){1'b1}}}) + NW'(div_out.neg[j]);
            sat[j]  = (div_out.num[j] > lim[j]);
            mag[j]  = sat[j] ? lim[j][CW-1:0] : div_out.num[j][CW-1:0];
            root[j] = div_out.neg[j] ? (~mag[j] + CW'(1)) : mag[j];
        end
        has_roots = (div_out.status == qrs_pkg::ST_DOUBLE) ||
                    (div_out.status == qrs_pkg::ST_TWO);
        result_next.status    = div_out.status;
        result_next.root_one  = has_roots ? root[0] : '0;
        result_next.root_two  = has_roots ? root[1] : '0;
        result_next.saturated = has_roots && (sat != 2'b00);
        case (div_out.status)
            qrs_pkg::ST_DOUBLE: result_next.root_count = 2'd1;
            qrs_pkg::ST_TWO:    result_next.root_count = 2'd2;
            default:            result_next.root_count = 2'd0;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // checks on the result word
    `QRS_ASSERT_IMPLIES(a_count_matches, out_valid_reg,
        ((result_reg.status == qrs_pkg::ST_NOT_QUAD || result_reg.status == qrs_pkg::ST_NO_REAL)
         == (result_reg.root_count == 2'd0)))
    `QRS_ASSERT_IMPLIES(a_no_roots_zero,
        out_valid_reg && (result_reg.root_count == 2'd0),
        (result_reg.root_one == '0) && (result_reg.root_two == '0) && !result_reg.saturated)
    `QRS_ASSERT_IMPLIES(a_double_equal,
        out_valid_reg && (result_reg.status == qrs_pkg::ST_DOUBLE),
        result_reg.root_one == result_reg.root_two)
    `QRS_ASSERT_ALWAYS(a_stall_only_when_held, in_stall == (out_valid_reg && out_stall))

endmodule

[tb/qrs_checker.sv]
// result checker for the quadratic root solver: watches both channels,
// computes expected roots per accepted equation and compares in order
// depends on qrs_pkg; the tolerance value is mirrored from the config port
`timescale 1ns / 1ps

module qrs_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [qrs_pkg::TOL_WIDTH-1:0] cfg_wr_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  qrs_pkg::coef_t                coef,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  qrs_pkg::result_t              result,
    output int                            errors,
    output int                            pending,
    output int                            status_seen [4],
    output int                            sat_seen
);

    logic [qrs_pkg::TOL_WIDTH-1:0] tol_mirror;
    qrs_pkg::result_t              expected_roots [$];

    // rounded n/(2a) in Q16.16 with clamping
    function automatic logic [qrs_pkg::COEF_WIDTH-1:0] divide_root(
        input logic signed [127:0] n,
        input logic                a_neg,
        input logic [63:0]         a_mag,
        inout logic                sat);
        logic [127:0] nmag;
        logic [127:0] q;
        logic [127:0] lim;
        logic         neg;
        nmag = (n < 0) ? -n : n;
        neg  = ((n < 0) != a_neg) && (nmag != 0);
        q    = ((nmag << qrs_pkg::FRAC_BITS) + 128'(a_mag)) / 128'(a_mag << 1);
        lim  = (128'd1 << (qrs_pkg::COEF_WIDTH - 1)) - (neg ? 128'd0 : 128'd1);
        if (q > lim)
        begin
            q   = lim;
            sat = 1'b1;
        end
        return neg ? qrs_pkg::COEF_WIDTH'(-q) : qrs_pkg::COEF_WIDTH'(q);
    endfunction

    // floor square root of a wide discriminant
    function automatic logic [63:0] disc_sqrt(input logic [127:0] d);
        logic [63:0]  r;
        logic [63:0]  t;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            t = r | (64'd1 << i);
            if (128'(t) * 128'(t) <= d)
                r = t;
        end
        return r;
    endfunction

    function automatic qrs_pkg::result_t solve_equation(
        input qrs_pkg::coef_t c,
        input logic [qrs_pkg::TOL_WIDTH-1:0] tol);
        qrs_pkg::result_t       r;
        logic signed [127:0]    a;
        logic signed [127:0]    b;
        logic signed [127:0]    cc;
        logic signed [127:0]    d;
        logic signed [127:0]    s;
        logic [63:0]            a_mag;
        logic                   sat;
        a     = 128'(c.coef_a);
        b     = 128'(c.coef_b);
        cc    = 128'(c.coef_c);
        a_mag = 64'((a < 0) ? -a : a);
        sat   = 1'b0;
        r     = '0;
        r.status = qrs_pkg::ST_NOT_QUAD;
        if (a_mag != 0 && a_mag >= 64'(tol))
        begin
            d = b * b - 4 * a * cc;
            if (d < 0)
                r.status = qrs_pkg::ST_NO_REAL;
            else if (d < (128'(tol) << qrs_pkg::FRAC_BITS) || d == 0)
            begin
                r.status     = qrs_pkg::ST_DOUBLE;
                r.root_count = 2'd1;
                r.root_one   = divide_root(-b, a < 0, a_mag, sat);
                r.root_two   = r.root_one;
            end
            else
            begin
                s            = $signed(128'(disc_sqrt(d)));
                r.status     = qrs_pkg::ST_TWO;
                r.root_count = 2'd2;
                r.root_one   = divide_root(s - b, a < 0, a_mag, sat);
                r.root_two   = divide_root(-s - b, a < 0, a_mag, sat);
            end
        end
        r.saturated = sat;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("mismatch %0t: %s got %0h expected %0h", $time, what, got, want);
    endtask

    assign pending = expected_roots.size();

    always @(posedge clk or negedge rst_n)
    begin
        qrs_pkg::result_t want;
        if (!rst_n)
        begin
            tol_mirror = qrs_pkg::TOL_RESET;
            expected_roots.delete();
            errors = 0;
            sat_seen = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        end
        else
        begin
            // output transfer check first, then new input
            if (out_valid && !out_stall)
            begin
                if (expected_roots.size() == 0)
                    report_mismatch("unexpected result", 64'(result), 64'd0);
                else
                begin
                    want = expected_roots.pop_front();
                    status_seen[want.status]++;
                    if (want.saturated) sat_seen++;
                    if (result.status !== want.status)
                        report_mismatch("status", 64'(result.status), 64'(want.status));
                    if (result.root_count !== want.root_count)
                        report_mismatch("root_count", 64'(result.root_count),
                                        64'(want.root_count));
                    if (result.root_one !== want.root_one)
                        report_mismatch("root_one", 64'(unsigned'(result.root_one)),
                                        64'(unsigned'(want.root_one)));
                    if (result.root_two !== want.root_two)
                        report_mismatch("root_two", 64'(unsigned'(result.root_two)),
                                        64'(unsigned'(want.root_two)));
                    if (result.saturated !== want.saturated)
                        report_mismatch("saturated", 64'(result.saturated),
                                        64'(want.saturated));
                end
            end
            if (in_valid && !in_stall)
                expected_roots.push_back(solve_equation(coef, tol_mirror));
            if (cfg_wr_en)
                tol_mirror = cfg_wr_data;
        end
    end
endmodule

[tb/testbench.sv]
// stimulus and verdict for the quadratic root solver
// depends on qrs_pkg, quadratic_root_solver and qrs_checker
`timescale 1ns / 1ps

module testbench;

    localparam int LATENCY    = 89;
    localparam int WATCHDOG   = 4000;
    localparam int RANDOM_N   = 1730;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [qrs_pkg::TOL_WIDTH-1:0] cfg_wr_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    qrs_pkg::coef_t                coef = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    qrs_pkg::result_t              result;
    int                            errors;
    int                            pending;
    int                            status_seen [4];
    int                            sat_seen;
    int                            idle_cycles = 0;
    bit                            sink_calm = 1'b0;
    bit                            hold_off = 1'b0;
    int                            sent = 0;

    always #5 clk = ~clk;

    quadratic_root_solver dut (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall), .coef(coef),
        .out_valid(out_valid), .out_stall(out_stall), .result(result)
    );

    qrs_checker checker_i (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall), .coef(coef),
        .out_valid(out_valid), .out_stall(out_stall), .result(result),
        .errors(errors), .pending(pending), .status_seen(status_seen),
        .sat_seen(sat_seen)
    );

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("watchdog expired with %0d results pending", pending);
            $display("** quadratic_root_solver: FAILED **");
            $finish;
        end
    end

    // receiver stall: random bursts, one long hold-off on request
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            else if (!sink_calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 7);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    task automatic write_tolerance(input logic [qrs_pkg::TOL_WIDTH-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // one transfer, with random gaps before it unless calm
    task automatic send_equation(input logic [31:0] a, input logic [31:0] b,
                                 input logic [31:0] c, input bit calm);
        int n;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        coef     <= '{coef_a: a, coef_b: b, coef_c: c};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000)) - 1000);
            2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            3: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
            4: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 40)) - 20) << 16;
        endcase
    endfunction

    // build equations mostly from chosen roots, sometimes from random coefficients, so every status shows up
    task automatic random_equation(input bit calm);
        logic signed [31:0] a;
        logic signed [31:0] r1;
        logic signed [31:0] r2;
        case ($urandom_range(0, 3))
            0: send_equation(pick_coef(), pick_coef(), pick_coef(), calm);
            default:
            begin
                a  = $signed($urandom_range(1, 8)) * ($urandom_range(0, 1) ? 1 : -1);
                r1 = $signed($urandom_range(0, 40)) - 20;
                r2 = $urandom_range(0, 2) == 0 ? r1 : $signed($urandom_range(0, 40)) - 20;
                // a(x-r1)(x-r2) in Q16.16 with perturbation on c
                send_equation(a << 16, (-a * (r1 + r2)) << 16,
                              ((a * r1 * r2) << 16) + $signed($urandom_range(0, 600)) - 300,
                              calm);
            end
        endcase
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, each status, zero a, zero tolerance
        send_equation(32'h0, 32'h10000, 32'h10000, 1);
        send_equation(32'h100, 32'h10000, 32'h10000, 1);
        send_equation(32'h10000, 32'h0, 32'h10000, 1);
        send_equation(32'h10000, 32'h20000, 32'h10000, 1);
        send_equation(32'h10000, 32'h0, 32'hFFFF0000, 1);
        send_equation(32'h1, 32'h7fffffff, 32'h0, 1);
        send_equation(32'h80000000, 32'h80000000, 32'h80000000, 1);
        send_equation(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1);
        send_equation(32'h80000000, 32'h7fffffff, 32'h7fffffff, 1);
        send_equation(32'hffffffff, 32'h80000000, 32'h0, 1);
        send_equation(32'h7fffffff, 32'h0, 32'h80000000, 1);
        send_equation(32'hFFFF0000, 32'h30000, 32'h0, 1);
        drain_pipeline();
        write_tolerance('0);
        send_equation(32'h0, 32'h5, 32'h5, 1);
        send_equation(32'h1, 32'h0, 32'h0, 1);
        send_equation(32'h10000, 32'h20000, 32'h10000, 1);
        send_equation(32'h10000, 32'h20000, 32'hFFFF, 1);
        drain_pipeline();
        write_tolerance(16'hFFFF);
        send_equation(32'hFFFF, 32'h0, 32'h0, 1);
        send_equation(32'h10000, 32'h1000, 32'h0, 1);
        send_equation(32'hFFFF0000, 32'h20000, 32'hFFFFC000, 1);

        // receiver holds off long while the sender keeps offering
        hold_off = 1'b1;
        for (int i = 0; i < 150; i++) random_equation(1);
        drain_pipeline();

        // random phases at different tolerances
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: write_tolerance(16'd655);
                1: write_tolerance(16'($urandom()));
                2: write_tolerance(16'd1);
                default: write_tolerance(16'($urandom_range(0, 2000)));
            endcase
            for (int i = 0; i < (RANDOM_N - 150) / 4; i++)
            begin
                if (p == 3 && i > 250) sink_calm = 1'b1;
                random_equation(p == 3 && i > 250);
            end
            drain_pipeline();
        end

        $display("sent %0d equations; statuses %0d/%0d/%0d/%0d, saturated %0d",
                 sent, status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 sat_seen);
        $display("tolerance swept over 0, 1, 655, 65535 and random values");
        if (errors == 0)
            $display("** quadratic_root_solver: PASSED **");
        else
            $display("** quadratic_root_solver: FAILED **");
        $finish;
    end
endmodule
